// File: rtl/ida_pkg.sv
package ida_pkg;

    localparam int ID_COUNT_DEF = 1024;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_INVALID   = 2'd1,
        ST_DOUBLE    = 2'd2,
        ST_EXHAUSTED = 2'd3
    } t_status;

    typedef enum logic {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } t_op;

endpackage

// File: rtl/ida_ram.sv
module ida_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 2
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        // old data on a same-address read, the caller forwards
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/id_recycling_allocator_unit.sv
// id recycling allocator
// hands out ids from 1 to ID_COUNT; freed ids are queued and handed out again
// oldest first before the high-water counter is raised further.
// request channel: an item (i_operation, i_release_id) is accepted on a rising
// edge with start high and busy low. busy is high only in the first cycle
// after reset, after that one item can be accepted every cycle.
// result channel: o_done is high for one cycle with o_granted_id and o_status;
// the item is registered in r_v, r_op and r_rid, and its result is then
// registered in r_done, r_granted and r_status (one item per cycle). the
// receiver cannot stall, so nothing is ever held back.
// the recycle queue and the freed marks sit in two single-port-write rams with
// a registered read; the read is launched at accept time, and a write made by
// the item ahead in the same cycle is forwarded to it.
// reset clears counters, pointers and flags only: a freed mark is written
// whenever its id is first issued, so the mark ram needs no clearing pass and
// marks of ids above the high-water counter are never looked at.
module id_recycling_allocator_unit
    import ida_pkg::*;
#(
    parameter int ID_COUNT = ID_COUNT_DEF,
    localparam int ID_W = $clog2(ID_COUNT + 1),
    localparam int IDX_W = $clog2(ID_COUNT)
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    output logic            busy,
    input  logic            i_operation,
    input  logic [ID_W-1:0] i_release_id,
    output logic            o_done,
    output logic [ID_W-1:0] o_granted_id,
    output logic [1:0]      o_status
);

    localparam logic [ID_W-1:0]  LIMIT    = ID_W'(ID_COUNT);
    localparam logic [IDX_W-1:0] LAST_POS = IDX_W'(ID_COUNT - 1);

    logic             r_busy;
    logic             r_v;
    logic             r_op;
    logic [ID_W-1:0]  r_rid;
    logic [IDX_W-1:0] r_head, n_head;
    logic [IDX_W-1:0] r_tail, n_tail;
    logic [ID_W-1:0]  r_count, n_count;
    logic [ID_W-1:0]  r_high_water, n_high_water;
    logic             r_fifo_fwd;
    logic [IDX_W-1:0] r_fifo_fwd_d;
    logic             r_mark_fwd;
    logic             r_mark_fwd_d;
    logic             r_done;
    logic [ID_W-1:0]  r_granted, n_granted;
    t_status          r_status, n_status;

    logic             accept;
    logic             fifo_we;
    logic [IDX_W-1:0] fifo_waddr;
    logic [IDX_W-1:0] fifo_wdata;
    logic [IDX_W-1:0] fifo_rdata;
    logic             mark_we;
    logic [IDX_W-1:0] mark_waddr;
    logic             mark_wdata;
    logic [IDX_W-1:0] mark_raddr;
    logic             mark_rdata;
    logic [IDX_W-1:0] slot;
    logic             mark;
    logic [IDX_W-1:0] rid_idx;

    assign busy   = r_busy;
    assign accept = start && !r_busy;

    assign slot       = r_fifo_fwd ? r_fifo_fwd_d : fifo_rdata;
    assign mark       = r_mark_fwd ? r_mark_fwd_d : mark_rdata;
    assign rid_idx    = IDX_W'(r_rid - ID_W'(1));
    assign mark_raddr = IDX_W'(i_release_id - ID_W'(1));

    always_comb begin
        n_head       = r_head;
        n_tail       = r_tail;
        n_count      = r_count;
        n_high_water = r_high_water;
        n_granted    = '0;
        n_status     = ST_OK;
        fifo_we      = 1'b0;
        fifo_waddr   = r_tail;
        fifo_wdata   = rid_idx;
        mark_we      = 1'b0;
        mark_waddr   = rid_idx;
        mark_wdata   = 1'b0;
        if (r_v) begin
            if (r_op == OP_ALLOC) begin
                priority if (r_count != '0) begin
                    n_head     = (r_head == LAST_POS) ? '0 : r_head + IDX_W'(1);
                    n_count    = r_count - ID_W'(1);
                    mark_we    = 1'b1;
                    mark_waddr = slot;
                    n_granted  = ID_W'(slot) + ID_W'(1);
                end else if (r_high_water == LIMIT) begin
                    n_status = ST_EXHAUSTED;
                end else begin
                    // first issue of this id: its mark starts out clear
                    n_high_water = r_high_water + ID_W'(1);
                    n_granted    = r_high_water + ID_W'(1);
                    mark_we      = 1'b1;
                    mark_waddr   = IDX_W'(r_high_water);
                end
            end else begin
                priority if (r_rid == '0 || r_rid > r_high_water) begin
                    n_status = ST_INVALID;
                end else if (mark || r_count == LIMIT) begin
                    n_status = ST_DOUBLE;
                end else begin
                    mark_we    = 1'b1;
                    mark_wdata = 1'b1;
                    fifo_we    = 1'b1;
                    n_tail     = (r_tail == LAST_POS) ? '0 : r_tail + IDX_W'(1);
                    n_count    = r_count + ID_W'(1);
                end
            end
        end
    end

    ida_ram #(
        .WIDTH (IDX_W),
        .DEPTH (ID_COUNT)
    ) u_fifo_ram (
        .i_clk   (i_clk),
        .i_we    (fifo_we),
        .i_waddr (fifo_waddr),
        .i_wdata (fifo_wdata),
        .i_raddr (n_head),
        .o_rdata (fifo_rdata)
    );

    ida_ram #(
        .WIDTH (1),
        .DEPTH (ID_COUNT)
    ) u_mark_ram (
        .i_clk   (i_clk),
        .i_we    (mark_we),
        .i_waddr (mark_waddr),
        .i_wdata (mark_wdata),
        .i_raddr (mark_raddr),
        .o_rdata (mark_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy       <= 1'b1;
            r_v          <= 1'b0;
            r_done       <= 1'b0;
            r_head       <= '0;
            r_tail       <= '0;
            r_count      <= '0;
            r_high_water <= '0;
        end else begin
            r_busy       <= 1'b0;
            r_v          <= accept;
            r_done       <= r_v;
            r_head       <= n_head;
            r_tail       <= n_tail;
            r_count      <= n_count;
            r_high_water <= n_high_water;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op         <= i_operation;
        r_rid        <= i_release_id;
        r_fifo_fwd   <= fifo_we && (fifo_waddr == n_head);
        r_fifo_fwd_d <= fifo_wdata;
        r_mark_fwd   <= mark_we && (mark_waddr == mark_raddr);
        r_mark_fwd_d <= mark_wdata;
        r_granted    <= n_granted;
        r_status     <= n_status;
    end

    assign o_done       = r_done;
    assign o_granted_id = r_granted;
    assign o_status     = r_status;

    a_fail_no_id: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && r_status != ST_OK) |-> (o_granted_id == '0))
        else $error("failed item carries an id");

    a_count_le_hw: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= r_high_water)
        else $error("recycle queue holds more ids than were issued");

    a_grant_le_hw: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_granted_id <= r_high_water))
        else $error("granted id above high-water counter");

    a_done_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v |=> o_done)
        else $error("item in flight produced no result");

endmodule
